/* design/acfd_pkg.sv */
package acfd_pkg;

    // Width of one stored value and of the search pointers.
    localparam int unsigned VALUE_W = 10;

    // One input transfer: a value of the set and the end-of-set marker.
    typedef struct packed {
        logic [VALUE_W-1:0] element_value;
        logic               last_element;
    } t_in;

    // One result transfer.
    typedef struct packed {
        logic [VALUE_W-1:0] duplicate;
        logic               error;
    } t_out;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_LOAD,
        S_CHECK,
        S_P1_A0,
        S_P1_T0,
        S_P1_H0,
        S_P1_CMP,
        S_P1_T,
        S_P1_H1,
        S_P1_H2,
        S_P2_CMP,
        S_P2_T,
        S_P2_H
    } t_state;

endpackage

/* design/acfd_ram.sv */
module acfd_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/array_duplicate_cycle_finder.sv */
// Duplicate finder by Floyd cycle search over a loaded set of values.
//
// Input channel: one value per transfer, last_element marking the end of a
// set. Entry i of the set is the successor of index i. Values of a set are
// loaded at one transfer per cycle while o_in_stall is low.
// After the final transfer the block stalls its input while it checks the
// set and walks the store. Every pointer move is a dependent read of the
// single read port of the value store: a phase one step runs compare,
// tortoise and two hare states, a phase two step compare, tortoise and hare;
// set-up starts both pointers from entry zero; each phase ends on a compare.
// A rejected set (fewer than two values, a value of zero or not below the
// set size, or more values than DEPTH) gives error 1 and duplicate 0 from the
// check state, once the output register is free.
// Output channel: one result per set, held in an output register until the
// transfer completes. Loading of the next set continues while that result
// waits; only the next set's result waits for the register to free up.
// Reset (synchronous, active low) empties the set and drops any pending
// result. The store itself is not cleared: the search only reads entries
// of the current set.
module array_duplicate_cycle_finder #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  acfd_pkg::t_in i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output acfd_pkg::t_out o_out
);

    localparam int unsigned VW   = acfd_pkg::VALUE_W;
    localparam int unsigned AW   = $clog2(DEPTH);
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = (CW > VW) ? CW : VW;

    acfd_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [VW-1:0]    r_max, n_max;
    logic             r_zero, n_zero;
    logic             r_bad, n_bad;
    logic [VW-1:0]    r_tort, n_tort;
    logic [VW-1:0]    r_hare, n_hare;
    logic             r_out_valid, n_out_valid;
    acfd_pkg::t_out   r_out, n_out;

    logic             in_xfer;
    logic             store_full;
    logic             set_ok;
    logic             out_free;
    logic             ram_we;
    logic [AW-1:0]    ram_raddr;
    logic [VW-1:0]    ram_rdata;

    // Handshake and set checks.
    assign o_in_stall = (r_state != acfd_pkg::S_LOAD);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign store_full = (r_count == CW'(DEPTH));
    assign set_ok     = !r_bad && !r_zero && (r_count >= CW'(2))
                        && (CMPW'(r_max) < CMPW'(r_count));
    assign out_free   = !r_out_valid || !i_out_stall;
    assign ram_we     = in_xfer && !store_full;

    // Value store.
    acfd_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in.element_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            acfd_pkg::S_LOAD: begin
                if (in_xfer && i_in.last_element) begin
                    n_state = acfd_pkg::S_CHECK;
                end
            end
            acfd_pkg::S_CHECK: begin
                if (set_ok) begin
                    n_state = acfd_pkg::S_P1_A0;
                end else if (out_free) begin
                    n_state = acfd_pkg::S_LOAD;
                end
            end
            acfd_pkg::S_P1_A0:  n_state = acfd_pkg::S_P1_T0;
            acfd_pkg::S_P1_T0:  n_state = acfd_pkg::S_P1_H0;
            acfd_pkg::S_P1_H0:  n_state = acfd_pkg::S_P1_CMP;
            acfd_pkg::S_P1_CMP: begin
                n_state = (r_tort == r_hare) ? acfd_pkg::S_P2_CMP : acfd_pkg::S_P1_T;
            end
            acfd_pkg::S_P1_T:   n_state = acfd_pkg::S_P1_H1;
            acfd_pkg::S_P1_H1:  n_state = acfd_pkg::S_P1_H2;
            acfd_pkg::S_P1_H2:  n_state = acfd_pkg::S_P1_CMP;
            acfd_pkg::S_P2_CMP: begin
                if (r_tort != r_hare) begin
                    n_state = acfd_pkg::S_P2_T;
                end else if (out_free) begin
                    n_state = acfd_pkg::S_LOAD;
                end
            end
            acfd_pkg::S_P2_T:   n_state = acfd_pkg::S_P2_H;
            acfd_pkg::S_P2_H:   n_state = acfd_pkg::S_P2_CMP;
            default:            n_state = acfd_pkg::S_LOAD;
        endcase
    end

    // Datapath controls: read address, pointers, set statistics, result.
    always_comb begin
        n_count     = r_count;
        n_max       = r_max;
        n_zero      = r_zero;
        n_bad       = r_bad;
        n_tort      = r_tort;
        n_hare      = r_hare;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_raddr   = AW'(r_tort);
        unique case (r_state)
            acfd_pkg::S_LOAD: begin
                if (in_xfer) begin
                    if (store_full) begin
                        n_bad = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                        if (i_in.element_value > r_max) begin
                            n_max = i_in.element_value;
                        end
                        if (i_in.element_value == '0) begin
                            n_zero = 1'b1;
                        end
                    end
                end
            end
            acfd_pkg::S_CHECK: begin
                ram_raddr = '0;
                if (set_ok || out_free) begin
                    n_count = '0;
                    n_max   = '0;
                    n_zero  = 1'b0;
                    n_bad   = 1'b0;
                end
                if (!set_ok && out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.duplicate = '0;
                    n_out.error     = 1'b1;
                end
            end
            acfd_pkg::S_P1_A0: begin
                ram_raddr = '0;
            end
            acfd_pkg::S_P1_T0: begin
                n_tort    = ram_rdata;
                ram_raddr = AW'(ram_rdata);
            end
            acfd_pkg::S_P1_H0: begin
                n_hare = ram_rdata;
            end
            acfd_pkg::S_P1_CMP: begin
                ram_raddr = AW'(r_tort);
                if (r_tort == r_hare) begin
                    n_tort = '0;
                end
            end
            acfd_pkg::S_P1_T: begin
                n_tort    = ram_rdata;
                ram_raddr = AW'(r_hare);
            end
            acfd_pkg::S_P1_H1: begin
                ram_raddr = AW'(ram_rdata);
            end
            acfd_pkg::S_P1_H2: begin
                n_hare = ram_rdata;
            end
            acfd_pkg::S_P2_CMP: begin
                ram_raddr = AW'(r_tort);
                if (r_tort == r_hare && out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.duplicate = r_tort;
                    n_out.error     = 1'b0;
                end
            end
            acfd_pkg::S_P2_T: begin
                n_tort    = ram_rdata;
                ram_raddr = AW'(r_hare);
            end
            acfd_pkg::S_P2_H: begin
                n_hare = ram_rdata;
            end
            default: begin
                ram_raddr = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= acfd_pkg::S_LOAD;
            r_count     <= '0;
            r_max       <= '0;
            r_zero      <= 1'b0;
            r_bad       <= 1'b0;
            r_tort      <= '0;
            r_hare      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_max       <= n_max;
            r_zero      <= n_zero;
            r_bad       <= n_bad;
            r_tort      <= n_tort;
            r_hare      <= n_hare;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A rejected set always reports a zero duplicate.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.error |-> o_out.duplicate == '0)
        else $error("error result with non-zero duplicate");

    // A found duplicate is never zero, since index zero has no predecessor.
    a_dup_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.error |-> o_out.duplicate != '0)
        else $error("search returned a zero duplicate");

    // The final transfer of a set always leads to the check state.
    a_last_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in.last_element |=> r_state == acfd_pkg::S_CHECK)
        else $error("final transfer did not start the set check");

    // A new result only comes from the check or the end of phase two.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == acfd_pkg::S_CHECK
                               || $past(r_state) == acfd_pkg::S_P2_CMP)
        else $error("result raised from an unexpected state");

endmodule
